### rtl/irc_line_tokenizer_core_macros.svh
// Assertion macros for the tokenizer RTL.
`ifndef IRC_LINE_TOKENIZER_CORE_MACROS_SVH
`define IRC_LINE_TOKENIZER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`endif

`endif

### rtl/irc_tok_pkg.sv
package irc_tok_pkg;

  localparam int unsigned MaxArgs = 15;
  localparam int unsigned TokW = 5;
  localparam int unsigned LimW = 6;

  localparam logic [7:0] CharColon = 8'h3a;
  localparam logic [7:0] CharNul = 8'h00;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab = 8'h09;
  localparam logic [7:0] CharCr = 8'h0d;

  typedef enum logic [1:0] {
    PhLead  = 2'd0,
    PhGap   = 2'd1,
    PhToken = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    RoleSkip    = 2'd0,
    RolePrefix  = 2'd1,
    RoleCommand = 2'd2,
    RoleArg     = 2'd3
  } role_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    role_e      role;
    logic [3:0] arg_index;
    logic       line_done;
    logic [3:0] arg_count;
  } out_item_t;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  endfunction

endpackage

### rtl/irc_line_tokenizer_core.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | in_item_i (in_item_t)
// out     | output    | out_valid_o / out_stall_i | out_item_o (out_item_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (arg_limit)
//
// One item per cycle sustained while out is not stalled; an accepted item passes through the
// input register, then the result register, before out_valid_o rises.
// The line state updates as an item moves into the result register.
// Reset clears valids, line state, and sets arg_limit to 15.
// A stall on out holds the result; in stalls only when both registers are full.
// cfg_ready_o is always high.
module irc_line_tokenizer_core #(
  parameter int unsigned ArgsMax = irc_tok_pkg::MaxArgs
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  irc_tok_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output irc_tok_pkg::out_item_t out_item_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [3:0]             cfg_data_i
);
  import irc_tok_pkg::*;

  logic [3:0] arg_limit_q;
  logic       stage_valid;
  logic       stage_adv;
  in_item_t   staged_item;
  out_item_t  result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arg_limit_q <= 4'(MaxArgs);
    end else if (cfg_valid_i && cfg_ready_o) begin
      arg_limit_q <= cfg_data_i;
    end
  end

  irc_tok_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .adv_i      (stage_adv),
    .valid_o    (stage_valid),
    .item_o     (staged_item)
  );

  irc_tok_fsm #(
    .ArgsMax (ArgsMax)
  ) u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (stage_adv),
    .item_i      (staged_item),
    .arg_limit_i (arg_limit_q),
    .result_o    (result)
  );

  irc_tok_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage_valid),
    .result_i    (result),
    .adv_o       (stage_adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );
endmodule

### rtl/irc_tok_in_stage.sv
module irc_tok_in_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  irc_tok_pkg::in_item_t in_item_i,
  input  logic                 adv_i,
  output logic                 valid_o,
  output irc_tok_pkg::in_item_t item_o
);
  import irc_tok_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  assign in_stall_o = valid_q && !adv_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

### rtl/irc_tok_fsm.sv
`include "irc_line_tokenizer_core_macros.svh"

module irc_tok_fsm #(
  parameter int unsigned ArgsMax = irc_tok_pkg::MaxArgs
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  irc_tok_pkg::in_item_t item_i,
  input  logic [3:0]            arg_limit_i,
  output irc_tok_pkg::out_item_t result_o
);
  import irc_tok_pkg::*;

  phase_e          phase_q, phase_d;
  logic            rest_q, rest_d;
  logic            prefix_q, prefix_d;
  logic [TokW-1:0] tok_q, tok_d;

  logic            is_end;
  logic            ws;
  logic [LimW-1:0] lim;
  logic [LimW-1:0] tok_next_ext;
  role_e           content_role;
  logic [3:0]      content_idx;

  assign is_end       = item_i.line_end || (item_i.char_in == CharNul);
  assign ws           = is_ws(item_i.char_in);
  assign tok_next_ext = LimW'(tok_q) + LimW'(1);

  always_comb begin
    lim = LimW'(arg_limit_i);
    if (arg_limit_i == 4'd0) begin
      lim = LimW'(1);
    end else if (LimW'(arg_limit_i) > LimW'(ArgsMax)) begin
      lim = LimW'(ArgsMax);
    end
  end

  always_comb begin
    content_idx = 4'd0;
    if (prefix_q) begin
      content_role = RolePrefix;
    end else if (tok_q == '0) begin
      content_role = RoleCommand;
    end else begin
      content_role = RoleArg;
      content_idx  = tok_q[3:0] - 4'd1;
    end
  end

  // next state
  always_comb begin
    phase_d  = phase_q;
    rest_d   = rest_q;
    prefix_d = prefix_q;
    tok_d    = tok_q;
    if (is_end) begin
      phase_d  = PhLead;
      rest_d   = 1'b0;
      prefix_d = 1'b0;
      tok_d    = '0;
    end else begin
      unique case (phase_q)
        PhToken: begin
          if (!rest_q && ws) begin
            phase_d = PhGap;
            if (prefix_q) begin
              prefix_d = 1'b0;
            end else begin
              if (tok_next_ext >= lim) begin
                rest_d = 1'b1;
              end
              if (tok_q != '1) begin
                tok_d = tok_q + TokW'(1);
              end
            end
          end
        end
        default: begin
          if (!ws) begin
            phase_d = PhToken;
            if (item_i.char_in == CharColon) begin
              if (tok_q != '0) begin
                rest_d = 1'b1;
              end else begin
                prefix_d = 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    result_o.char_out  = item_i.char_in;
    result_o.role      = RoleSkip;
    result_o.arg_index = 4'd0;
    result_o.line_done = 1'b0;
    result_o.arg_count = 4'd0;
    if (is_end) begin
      result_o.line_done = 1'b1;
      result_o.arg_count = prefix_q ? 4'd0 : tok_q[3:0];
    end else if (phase_q == PhToken) begin
      if (rest_q || !ws) begin
        result_o.role      = content_role;
        result_o.arg_index = content_idx;
      end
    end else if (!ws && (item_i.char_in != CharColon)) begin
      result_o.role      = content_role;
      result_o.arg_index = content_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhLead;
      rest_q   <= 1'b0;
      prefix_q <= 1'b0;
      tok_q    <= '0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      rest_q   <= rest_d;
      prefix_q <= prefix_d;
      tok_q    <= tok_d;
    end
  end

  `ASSERT_ALWAYS(a_tok_bounded, clk_i, rst_ni, tok_q <= TokW'(MaxArgs), "token count past limit")
  `ASSERT_IMPLY(a_rest_has_cmd, clk_i, rst_ni, rest_q, tok_q != '0, "rest of line before command")
  `ASSERT_IMPLY(a_prefix_first, clk_i, rst_ni, prefix_q, tok_q == '0, "prefix after command")
  `ASSERT_IMPLY(a_lead_flags, clk_i, rst_ni, phase_q == PhLead, !rest_q && !prefix_q, "lead flags")
  `ASSERT_IMPLY(a_lead_tok, clk_i, rst_ni, phase_q == PhLead, tok_q == '0, "lead token count")
endmodule

### rtl/irc_tok_out_stage.sv
module irc_tok_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  irc_tok_pkg::out_item_t result_i,
  output logic                   adv_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output irc_tok_pkg::out_item_t out_item_o
);
  import irc_tok_pkg::*;

  logic      valid_q, valid_d;
  out_item_t item_q;

  assign adv_o = valid_i && (!valid_q || !out_stall_i);

  always_comb begin
    valid_d = valid_q;
    if (adv_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;
endmodule
